/* rtl/cross_edge_preserving_denoise_top_assert.svh */
// assertion macros used by the rtl controller
`ifndef CROSS_EDGE_PRESERVING_DENOISE_TOP_ASSERT_SVH
`define CROSS_EDGE_PRESERVING_DENOISE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CEPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CEPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cepd_pkg.sv */
`timescale 1ns / 1ps
package cepd_pkg;
	localparam int MaxWidth = 2048;
	localparam int AddrW = $clog2(MaxWidth);

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;
	localparam logic [1:0] REG_BLEND = 2'd3;

	typedef struct packed {
		logic       accept;
		logic       rd_a;
		logic       rd_b;
		logic       rd_c;
		logic       nb_step;
		logic [1:0] nb_sel;
		logic       div_init;
		logic       div_step;
		logic [2:0] div_bit;
		logic       blend;
		logic [1:0] chan;
		logic       emit;
	} cepd_cmd_t;

	typedef struct packed {
		logic ignore;
		logic is_flush;
		logic emit;
		logic border;
		logic out_free;
	} cepd_sts_t;
endpackage

/* rtl/cepd_ctrl.sv */
`timescale 1ns / 1ps
`include "cross_edge_preserving_denoise_top_assert.svh"
module cepd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  cepd_pkg::cepd_sts_t sts,
	output cepd_pkg::cepd_cmd_t cmd
);
	import cepd_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDA  = 4'd1;
	localparam logic [3:0] S_RDB  = 4'd2;
	localparam logic [3:0] S_RDC  = 4'd3;
	localparam logic [3:0] S_NB   = 4'd4;
	localparam logic [3:0] S_DINI = 4'd5;
	localparam logic [3:0] S_DIVS = 4'd6;
	localparam logic [3:0] S_BLND = 4'd7;
	localparam logic [3:0] S_WOUT = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [2:0] bit_q, bit_d;
	logic [1:0] chan_q, chan_d;

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		bit_d = bit_q;
		chan_d = chan_q;
		cmd = '0;
		cmd.nb_sel = k_q;
		cmd.div_bit = bit_q;
		cmd.chan = chan_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && !sts.ignore)
					state_d = S_RDA;
			end
			S_RDA: begin
				cmd.rd_a = 1'b1;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.rd_b = 1'b1;
				state_d = sts.is_flush ? S_WOUT : S_RDC;
			end
			S_RDC: begin
				cmd.rd_c = 1'b1;
				k_d = 2'd0;
				if (!sts.emit)
					state_d = S_IDLE;
				else if (sts.border)
					state_d = S_WOUT;
				else
					state_d = S_NB;
			end
			S_NB: begin
				cmd.nb_step = 1'b1;
				k_d = k_q + 2'd1;
				if (k_q == 2'd3) begin
					chan_d = 2'd0;
					state_d = S_DINI;
				end
			end
			S_DINI: begin
				cmd.div_init = 1'b1;
				bit_d = 3'd7;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_step = 1'b1;
				bit_d = bit_q - 3'd1;
				if (bit_q == 3'd0)
					state_d = S_BLND;
			end
			S_BLND: begin
				cmd.blend = 1'b1;
				if (chan_q == 2'd2) begin
					state_d = S_WOUT;
				end else begin
					chan_d = chan_q + 2'd1;
					state_d = S_DINI;
				end
			end
			S_WOUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			bit_q <= '0;
			chan_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			bit_q <= bit_d;
			chan_q <= chan_d;
		end
	end

	`CEPD_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "result loaded into a busy output")
	`CEPD_ASSERT_NXT(a_div_to_blend, state_q == S_DIVS && bit_q == 3'd0, state_q == S_BLND,
		"divide did not end in blend")
	`CEPD_ASSERT_NXT(a_accept_starts, state_q == S_IDLE && s_tvalid && !sts.ignore,
		state_q == S_RDA, "accepted transaction did not start a read")
endmodule

/* rtl/cepd_dp.sv */
`timescale 1ns / 1ps
module cepd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata,
	input  logic [31:0]        s_tdata,
	input  logic               s_tuser,
	output logic [31:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  cepd_pkg::cepd_cmd_t cmd,
	output cepd_pkg::cepd_sts_t sts
);
	import cepd_pkg::*;

	function automatic logic [7:0] chan_of(logic [31:0] p, logic [1:0] k);
		logic [7:0] v;
		case (k)
			2'd0: v = p[23:16];
			2'd1: v = p[15:8];
			default: v = p[7:0];
		endcase
		return v;
	endfunction

	function automatic logic [9:0] rgb_diff(logic [31:0] a, logic [31:0] b);
		logic [9:0] d;
		d = '0;
		for (int i = 0; i < 3; i++) begin
			if (chan_of(a, 2'(i)) > chan_of(b, 2'(i)))
				d = d + 10'(chan_of(a, 2'(i)) - chan_of(b, 2'(i)));
			else
				d = d + 10'(chan_of(b, 2'(i)) - chan_of(a, 2'(i)));
		end
		return d;
	endfunction

	// configuration
	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  thresh_q;
	logic [8:0]  blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 16'd480;
			thresh_q <= 8'd52;
			blend_q <= 9'd128;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:  width_q <= cfg_wdata[11:0];
				REG_HEIGHT: height_q <= cfg_wdata;
				REG_THRESH: thresh_q <= cfg_wdata[7:0];
				REG_BLEND:  blend_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	logic [11:0] w_eff;
	logic [15:0] h_eff;
	logic [9:0]  t3;
	logic [8:0]  bl;
	assign w_eff = (width_q == 12'd0) ? 12'd1 :
		(width_q > 12'(MaxWidth)) ? 12'(MaxWidth) : width_q;
	assign h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	assign t3 = {1'b0, thresh_q, 1'b0} + {2'b0, thresh_q};
	assign bl = (blend_q > 9'd256) ? 9'd256 : blend_q;

	// position counters
	logic [AddrW-1:0] col_q;
	logic [15:0]      row_q;
	logic [11:0]      pend_q;
	logic [11:0]      col_next;
	logic [12:0]      pend_next;
	logic             row_end;

	assign col_next = {1'b0, col_q} + 12'd1;
	assign pend_next = {1'b0, pend_q} + 13'd1;
	assign row_end = col_next >= w_eff;

	assign sts.ignore = s_tuser ? (row_q < h_eff) : (row_q >= h_eff);

	// latched item
	logic [31:0]      px_q;
	logic             flush_q;
	logic [AddrW-1:0] c_q;
	logic [AddrW-1:0] pa_q;
	logic             emit_q, border_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pend_q <= '0;
			flush_q <= 1'b0;
			emit_q <= 1'b0;
			border_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.accept && !sts.ignore) begin
			flush_q <= s_tuser;
			if (s_tuser) begin
				last_q <= pend_next >= {1'b0, w_eff};
				if (pend_next >= {1'b0, w_eff}) begin
					pend_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					pend_q <= pend_next[11:0];
				end
			end else begin
				last_q <= 1'b0;
				emit_q <= row_q != 16'd0;
				border_q <= (row_q == 16'd1) || (row_q >= h_eff) || (col_q == '0) || row_end;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 16'd1;
					pend_q <= '0;
				end else begin
					col_q <= col_next[AddrW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= s_tdata;
			c_q <= col_q;
			pa_q <= pend_q[AddrW-1:0];
		end
	end

	// line stores
	logic [31:0] upp_mem [MaxWidth];
	logic [31:0] mid_mem [MaxWidth];
	logic [31:0] upp_rd, mid_rd;
	logic [AddrW-1:0] mid_ra;
	logic [31:0] centre_q, up_q, left_q, right_q, prev_q;

	always_comb begin
		if (cmd.rd_b)
			mid_ra = c_q + AddrW'(1);
		else if (flush_q)
			mid_ra = pa_q;
		else
			mid_ra = c_q;
	end

	always_ff @(posedge clk) begin
		mid_rd <= mid_mem[mid_ra];
		upp_rd <= upp_mem[c_q];
		if (cmd.rd_c) begin
			upp_mem[c_q] <= centre_q;
			mid_mem[c_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_q <= '0;
		else if (cmd.rd_b && !flush_q)
			prev_q <= mid_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_b) begin
			centre_q <= mid_rd;
			up_q <= upp_rd;
			left_q <= prev_q;
		end
		if (cmd.rd_c)
			right_q <= mid_rd;
	end

	// weighted sums
	logic [19:0] sum_q [3];
	logic [11:0] cnt_q;
	logic [31:0] nb;
	logic [9:0]  d;

	always_comb begin
		case (cmd.nb_sel)
			2'd0: nb = up_q;
			2'd1: nb = px_q;
			2'd2: nb = left_q;
			default: nb = right_q;
		endcase
	end
	assign d = rgb_diff(centre_q, nb);

	always_ff @(posedge clk) begin
		if (cmd.rd_c) begin
			for (int i = 0; i < 3; i++)
				sum_q[i] <= {10'd0, chan_of(mid_rd, 2'd0) & 8'h00, 2'b00} |
					{10'd0, chan_of(centre_q, 2'(i)), 2'b00};
			cnt_q <= 12'd4;
		end else if (cmd.nb_step && d < t3) begin
			for (int i = 0; i < 3; i++)
				sum_q[i] <= sum_q[i] + 20'(chan_of(nb, 2'(i))) * 20'(t3 - d);
			cnt_q <= cnt_q + {2'b0, t3 - d};
		end
	end

	// restoring divide, quotient fits eight bits
	logic [19:0] rem_q;
	logic [7:0]  quo_q;
	logic [19:0] dv;
	assign dv = {8'd0, cnt_q} << cmd.div_bit;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= sum_q[cmd.chan];
			quo_q <= '0;
		end else if (cmd.div_step && rem_q >= dv) begin
			rem_q <= rem_q - dv;
			quo_q[cmd.div_bit] <= 1'b1;
		end
	end

	// blend
	logic [7:0]  res_q [3];
	logic [17:0] mix;
	logic [7:0]  cv;
	assign cv = chan_of(centre_q, cmd.chan);
	assign mix = 18'(cv) * 18'(9'd256 - bl) + 18'(quo_q) * 18'(bl);

	always_ff @(posedge clk) begin
		if (cmd.blend)
			res_q[cmd.chan] <= (mix[17:8] > 10'd255) ? 8'hFF : mix[15:8];
	end

	// output register
	logic        ovalid_q;
	logic [31:0] odata_q;
	logic        olast_q;

	assign sts.out_free = !ovalid_q || m_tready;
	assign sts.is_flush = flush_q;
	assign sts.emit = emit_q;
	assign sts.border = border_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			odata_q <= (flush_q || border_q) ? centre_q : {8'hFF, res_q[0], res_q[1], res_q[2]};
			olast_q <= flush_q && last_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = odata_q;
	assign m_tlast = olast_q;
endmodule

/* rtl/cross_edge_preserving_denoise_top.sv */
`timescale 1ns / 1ps
// edge-preserving denoise on a raster ARGB stream: each interior pixel is mixed with a
// weighted mean of itself and its up, down, left and right neighbours, borders pass
// through, and output for a row leaves while the next row enters. one transaction at a
// time: a flush does two store reads and the output load, a first-row pixel three store
// reads, a border pixel three store reads and the output load, an interior pixel three
// store reads, four neighbour weighting steps, per channel an 8-step shared divider with
// its load and a blend step, then the output load, held while the output register is
// full. an ignored transaction is dropped. the next input is taken while a result waits
// on the output register. tuser=1 marks a flush transaction that drains the last row.
module cross_edge_preserving_denoise_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_in
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_out
	output logic        m_tlast
);
	import cepd_pkg::*;

	cepd_cmd_t cmd;
	cepd_sts_t sts;

	cepd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	cepd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cmd(cmd), .sts(sts)
	);
endmodule

/* test/cross_edge_preserving_denoise_top_tb.sv */
`timescale 1ns / 1ps
module cross_edge_preserving_denoise_top_tb;
	import cepd_pkg::*;

	typedef struct {
		logic [31:0] px;
		logic        last;
	} out_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // pixel_in
	logic        s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // pixel_out
	logic        m_tlast;

	cross_edge_preserving_denoise_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	localparam bit ACT_PIXEL = 1'b0;
	localparam bit ACT_FLUSH = 1'b1;
	localparam int SETTLE = 60;
	localparam int CYCLE_LIMIT = 2000000;

	// predictor state
	int unsigned width_reg, height_reg, thresh_reg, blend_reg;
	bit [31:0] above_row[MaxWidth];
	bit [31:0] last_row[MaxWidth];
	bit [31:0] prev_centre;
	int unsigned col_cnt, row_cnt, drain_cnt;

	out_pixel_t pending_px[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cross_edge_preserving_denoise_top_tb: errors");
			$finish;
		end
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MaxWidth) return MaxWidth;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic logic [31:0] denoise_px(logic [31:0] c, logic [31:0] n0,
			logic [31:0] n1, logic [31:0] n2, logic [31:0] n3);
		logic [31:0] nb [4];
		int unsigned t3, bl, cnt, d, wgt, avg, f;
		int unsigned sum [3];
		logic [31:0] res;
		nb[0] = n0; nb[1] = n1; nb[2] = n2; nb[3] = n3;
		t3 = 3 * thresh_reg;
		bl = (blend_reg > 256) ? 256 : blend_reg;
		cnt = 4;
		res = 32'hFF00_0000;
		for (int k = 0; k < 3; k++) sum[k] = 4 * c[16 - 8 * k +: 8];
		for (int i = 0; i < 4; i++) begin
			d = 0;
			for (int k = 0; k < 3; k++) begin
				if (c[16 - 8 * k +: 8] > nb[i][16 - 8 * k +: 8])
					d += c[16 - 8 * k +: 8] - nb[i][16 - 8 * k +: 8];
				else
					d += nb[i][16 - 8 * k +: 8] - c[16 - 8 * k +: 8];
			end
			if (d < t3) begin
				wgt = t3 - d;
				for (int k = 0; k < 3; k++) sum[k] += nb[i][16 - 8 * k +: 8] * wgt;
				cnt += wgt;
			end
		end
		for (int k = 0; k < 3; k++) begin
			avg = sum[k] / cnt;
			f = (c[16 - 8 * k +: 8] * (256 - bl) + avg * bl) >> 8;
			if (f > 255) f = 255;
			res[16 - 8 * k +: 8] = f[7:0];
		end
		return res;
	endfunction

	// returns 1 when the transaction yields a pixel
	function automatic bit predict_pixel(bit act, logic [31:0] px,
			output logic [31:0] o, output logic last);
		int unsigned w, h, c;
		logic [31:0] centre, up, left, right;
		bit hit;
		w = eff_width();
		h = eff_height();
		hit = 0;
		o = '0;
		last = 1'b0;
		if (act == ACT_FLUSH) begin
			if (row_cnt < h) return 0;
			last = (drain_cnt + 1 >= w);
			o = last_row[drain_cnt];
			if (last) begin
				drain_cnt = 0;
				col_cnt = 0;
				row_cnt = 0;
			end else begin
				drain_cnt++;
			end
			return 1;
		end
		if (row_cnt >= h) return 0;
		c = col_cnt;
		centre = last_row[c];
		up = above_row[c];
		left = prev_centre;
		right = (c + 1 < MaxWidth) ? last_row[c + 1] : '0;
		prev_centre = centre;
		if (row_cnt >= 1) begin
			if (row_cnt == 1 || row_cnt >= h || c == 0 || c + 1 >= w)
				o = centre;
			else
				o = denoise_px(centre, up, px, left, right);
			hit = 1;
		end
		above_row[c] = last_row[c];
		last_row[c] = px;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt++;
			drain_cnt = 0;
		end else begin
			col_cnt = c + 1;
		end
		return hit;
	endfunction

	// receiver: random stalls, forced hold-off, result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_px.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected output transaction px=%h last=%b", m_tdata, m_tlast);
				end else begin
					out_pixel_t e;
					e = pending_px.pop_front();
					if (m_tdata !== e.px || m_tlast !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected px=%h last=%b, got px=%h last=%b",
								e.px, e.last, m_tdata, m_tlast);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(bit act, logic [31:0] px);
		logic [31:0] o;
		logic l;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		if (predict_pixel(act, px, o, l)) pending_px.push_back('{o, l});
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] w, logic [15:0] h, logic [15:0] t, logic [15:0] b);
		logic [15:0] vals [4];
		vals[0] = w; vals[1] = h; vals[2] = t; vals[3] = b;
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 2'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			case (2'(i))
				REG_WIDTH:  width_reg = vals[i] & 16'h0FFF;
				REG_HEIGHT: height_reg = vals[i];
				REG_THRESH: thresh_reg = vals[i] & 16'h00FF;
				REG_BLEND:  blend_reg = vals[i] & 16'h01FF;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] noisy_px(logic [23:0] base, int amp);
		logic [31:0] p;
		int v;
		if ($urandom_range(99) < 15) return $urandom;
		p[31:24] = 8'($urandom);
		for (int k = 0; k < 3; k++) begin
			v = int'(base[8 * k +: 8]) + int'($urandom_range(2 * amp)) - amp;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			p[8 * k +: 8] = v[7:0];
		end
		return p;
	endfunction

	// full frame with optional stray transactions that the block must skip
	task automatic run_frame(bit strays);
		logic [23:0] base;
		int amp;
		int unsigned w, h;
		base = 24'($urandom);
		amp = $urandom_range(0, 70);
		w = eff_width();
		h = eff_height();
		for (int unsigned i = 0; i < w * h; i++) begin
			if (strays && $urandom_range(99) < 3) send_item(ACT_FLUSH, $urandom);
			send_item(ACT_PIXEL, noisy_px(base, amp));
		end
		if (strays && $urandom_range(99) < 30) send_item(ACT_PIXEL, $urandom);
		for (int unsigned i = 0; i < w; i++) send_item(ACT_FLUSH, $urandom);
	endtask

	task automatic test_directed();
		logic [31:0] pix [12];
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'd4, 16'd3, 16'd255, 16'd256);
		pix = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8010_2030, 32'h00FF_00FF,
			32'h7F80_8080, 32'h0080_8080, 32'hFF7F_7F7F, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h1280_8282, 32'h0000_00FF, 32'hAAFF_FF00};
		send_item(ACT_FLUSH, 32'h0);
		for (int i = 0; i < 12; i++) send_item(ACT_PIXEL, pix[i]);
		send_item(ACT_PIXEL, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) send_item(ACT_FLUSH, 32'hFFFF_FFFF);
		set_config(16'd0, 16'd0, 16'd0, 16'd0);
		send_item(ACT_PIXEL, 32'hFFFF_FFFF);
		send_item(ACT_FLUSH, 32'h0);
	endtask

	task automatic test_random_frames(int frames, int idle_pct, int stall_pct);
		int sel;
		logic [15:0] w, h, t, b;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int f = 0; f < frames; f++) begin
			sel = $urandom_range(99);
			w = (sel < 10) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 16));
			h = (sel > 92) ? 16'd0 : 16'($urandom_range(1, 6));
			sel = $urandom_range(99);
			t = (sel < 10) ? 16'd0 : (sel < 20) ? 16'hFFFF : 16'($urandom);
			sel = $urandom_range(99);
			b = (sel < 10) ? 16'd0 : (sel < 20) ? 16'd256 : (sel < 25) ? 16'h01FF
				: 16'($urandom_range(51, 218)) | (16'($urandom) & 16'hFE00);
			set_config(w, h, t, b);
			run_frame(1'b1);
		end
	endtask

	// height raised to its maximum, then lowered once part of the frame is in
	task automatic test_tall_frame();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		set_config(16'd5, 16'hFFFF, 16'd40, 16'd200);
		for (int i = 0; i < 15; i++) send_item(ACT_PIXEL, noisy_px(24'h806040, 30));
		set_config(16'd5, 16'd4, 16'd40, 16'd200);
		for (int i = 0; i < 5; i++) send_item(ACT_PIXEL, noisy_px(24'h806040, 30));
		for (int i = 0; i < 5; i++) send_item(ACT_FLUSH, 32'h0);
	endtask

	task automatic test_wide_row();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'd200, 16'd2, 16'd52, 16'd128);
		run_frame(1'b0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(16'd6, 16'd4, 16'd30, 16'd180);
		hold_left = 500;
		run_frame(1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		errors = 0;
		cycles = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		width_reg = 640;
		height_reg = 480;
		thresh_reg = 52;
		blend_reg = 128;
		prev_centre = '0;
		col_cnt = 0;
		row_cnt = 0;
		drain_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tall_frame();
		test_backpressure();
		test_random_frames(4, 0, 0);
		test_random_frames(4, 82, 0);
		test_random_frames(4, 0, 82);
		test_random_frames(4, 20, 20);
		test_wide_row();

		wait_idle();
		if (errors == 0)
			$display("cross_edge_preserving_denoise_top_tb: clean");
		else
			$display("cross_edge_preserving_denoise_top_tb: errors");
		$finish;
	end
endmodule
